FILE: sv/r2a_pkg.sv
// Shared types, constants and the digit-to-ASCII function for the radix to ASCII converter.
package r2a_pkg;

    localparam int unsigned DIGIT_W   = 6;   // holds any digit or base up to 36
    localparam int unsigned DIV_STEPS = 8;   // quotient bits resolved per divider cycle

    localparam logic [DIGIT_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_DEFAULT = 6'd10;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_NONE    = 8'h00;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // take the input word, set up the first division
        logic div_step;   // one divider pass
        logic store;      // write the remainder as a digit, restart the divider
        logic rd;         // fetch the next digit, most significant first
        logic put_sign;   // present '-'
        logic put_digit;  // present the fetched digit
        logic put_empty;  // present the empty marker
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic reject;     // negative value in a base other than ten
        logic minus;      // negative value in base ten
        logic pass_done;  // current divider pass is the final one for this digit
        logic quot_zero;  // quotient left after the last digit is zero
        logic out_taken;  // output word accepted this cycle
        logic out_last;   // output word carries the last flag
    } t_sts;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic up);
        logic [7:0] d8;
        d8 = {{(8-DIGIT_W){1'b0}}, d};
        if (d < 6'd10) begin
            return CHAR_ZERO + d8;
        end
        return (up ? CHAR_UPPER_A : CHAR_LOWER_A) + d8 - 8'd10;
    endfunction

endpackage

FILE: sv/r2a_ctrl.sv
// Controller state machine for the radix to ASCII converter.
module r2a_ctrl import r2a_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_DIVIDE = 7'b0000100,
        S_STORE  = 7'b0001000,
        S_READ   = 7'b0010000,
        S_PUT    = 7'b0100000,
        S_HOLD   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.reject) begin
                    o_cmd.put_empty = 1'b1;
                    n_state         = S_HOLD;
                end else begin
                    n_state = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.pass_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (!i_sts.quot_zero) begin
                    n_state = S_DIVIDE;
                end else if (i_sts.minus) begin
                    o_cmd.put_sign = 1'b1;
                    n_state        = S_HOLD;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_PUT;
            end
            S_PUT: begin
                o_cmd.put_digit = 1'b1;
                n_state         = S_HOLD;
            end
            S_HOLD: begin
                if (i_sts.out_taken) begin
                    n_state = i_sts.out_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/r2a_dpath.sv
// Datapath: input registers, digit divider, digit store and output register.
module r2a_dpath import r2a_pkg::*; #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [VALUE_BITS-1:0] i_number,
    input  logic [7:0]                   i_radix,
    input  logic                         i_upper_case,
    input  t_cmd                         i_cmd,
    output t_sts                         o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_character,
    output logic                         o_last,
    output logic                         o_empty_res
);

    localparam int unsigned DIV_PASSES = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int unsigned PAD_BITS   = DIV_PASSES * DIV_STEPS;
    localparam int unsigned PASS_W     = (DIV_PASSES > 1) ? $clog2(DIV_PASSES) : 1;
    localparam int unsigned ADDR_W     = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic [DIGIT_W-1:0]    base_eff;

    logic [DIGIT_W-1:0]  r_base;
    logic                r_upper;
    logic                r_reject;
    logic                r_minus;
    logic [PAD_BITS-1:0] r_quo;
    logic [PAD_BITS-1:0] n_quo;
    logic [DIGIT_W-1:0]  r_rem;
    logic [DIGIT_W-1:0]  n_rem;
    logic [PASS_W-1:0]   r_pass;
    logic [ADDR_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]   rd_addr;
    logic [DIGIT_W-1:0]  r_rd;

    logic [DIGIT_W-1:0]  r_mem [VALUE_BITS];

    logic [DIGIT_W-1:0]  c_rem;
    logic [DIGIT_W:0]    c_part;
    logic [PAD_BITS-1:0] c_quo;

    logic                r_out_valid;
    logic [7:0]          r_char;
    logic                r_last;
    logic                r_empty;

    assign neg      = i_number[VALUE_BITS-1];
    assign mag      = neg ? (~$unsigned(i_number) + 1'b1) : $unsigned(i_number);
    assign base_eff = (i_radix < {2'b00, RADIX_MIN} || i_radix > {2'b00, RADIX_MAX})
                      ? RADIX_DEFAULT : i_radix[DIGIT_W-1:0];
    assign rd_addr  = r_cnt - 1'b1;

    // Restoring division, several quotient bits per pass; quotient shifts in behind dividend
    always_comb begin
        c_rem  = r_rem;
        c_quo  = r_quo;
        c_part = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            c_part = {c_rem, c_quo[PAD_BITS-1]};
            c_quo  = {c_quo[PAD_BITS-2:0], 1'b0};
            if (c_part >= {1'b0, r_base}) begin
                c_part   = c_part - {1'b0, r_base};
                c_quo[0] = 1'b1;
            end
            c_rem = c_part[DIGIT_W-1:0];
        end
        n_rem = c_rem;
        n_quo = c_quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base   <= base_eff;
            r_upper  <= i_upper_case;
            r_reject <= neg && (base_eff != RADIX_DEFAULT);
            r_minus  <= neg && (base_eff == RADIX_DEFAULT);
            r_quo    <= PAD_BITS'(mag);
        end else if (i_cmd.div_step) begin
            r_quo <= n_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_pass <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.load || i_cmd.store) begin
                r_rem  <= '0;
                r_pass <= '0;
            end else if (i_cmd.div_step) begin
                r_rem  <= n_rem;
                r_pass <= r_pass + 1'b1;
            end
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.store) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.rd) begin
                r_cnt <= rd_addr;
            end
        end
    end

    // Digit store: least significant digit written first, read back in reverse
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_cnt] <= r_rem;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put_sign || i_cmd.put_digit || i_cmd.put_empty) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_sign) begin
            r_char  <= CHAR_MINUS;
            r_last  <= 1'b0;
            r_empty <= 1'b0;
        end else if (i_cmd.put_digit) begin
            r_char  <= digit_char(r_rd, r_upper);
            r_last  <= (r_cnt == '0);
            r_empty <= 1'b0;
        end else if (i_cmd.put_empty) begin
            r_char  <= CHAR_NONE;
            r_last  <= 1'b1;
            r_empty <= 1'b1;
        end
    end

    assign o_sts.reject    = r_reject;
    assign o_sts.minus     = r_minus;
    assign o_sts.pass_done = (r_pass == PASS_W'(DIV_PASSES - 1));
    assign o_sts.quot_zero = (r_quo == '0);
    assign o_sts.out_taken = r_out_valid && i_out_ready;
    assign o_sts.out_last  = r_last;

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;

endmodule

FILE: sv/radix_to_ascii_converter.sv
// Top level of the radix to ASCII converter.
// Converts a signed integer to ASCII in base 2..36 (other bases mean ten), most significant
// character first, one character per output word, last flag on the final one. A negative
// value gets a leading '-' in base ten; in any other base it gives one word with empty_res
// set and character zero. One number is handled at a time: an input word is taken only when
// the previous number's final word has gone. Each digit is worked out in the shared divider
// (eight quotient bits a cycle), and each character then passes through the digit store read
// port and the output register.
module radix_to_ascii_converter import r2a_pkg::*; #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [VALUE_BITS-1:0] i_number,
    input  logic [7:0]                   i_radix,
    input  logic                         i_upper_case,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_character,
    output logic                         o_last,
    output logic                         o_empty_res
);

    t_cmd cmd;
    t_sts sts;

    r2a_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    r2a_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_number     (i_number),
        .i_radix      (i_radix),
        .i_upper_case (i_upper_case),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_character  (o_character),
        .o_last       (o_last),
        .o_empty_res  (o_empty_res)
    );

endmodule

FILE: sv/r2a_chk.sv
// Port-level checker for the radix to ASCII converter, bound to the top level.
module r2a_chk import r2a_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_character,
    input logic       o_last,
    input logic       o_empty_res
);

    // An empty marker is a single zero word that closes the number
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_res |-> o_last && (o_character == CHAR_NONE))
        else $error("empty marker without last flag or with a character");

    // A sign is always followed by digits
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_character == CHAR_MINUS) |-> !o_last && !o_empty_res)
        else $error("minus sign flagged as last or empty");

    // No new number is taken while a word of the current one is pending
    a_one_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while output word pending");

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_character)
            && $stable(o_last) && $stable(o_empty_res))
        else $error("stalled output word changed");

endmodule

bind radix_to_ascii_converter r2a_chk u_r2a_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_character (o_character),
    .o_last      (o_last),
    .o_empty_res (o_empty_res)
);
